/* hdl/grid_max_path_sum_with_wall_core_assert.svh */
// Assertion macros shared by the grid path-sum RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef GRID_MAX_PATH_SUM_WITH_WALL_CORE_ASSERT_SVH
`define GRID_MAX_PATH_SUM_WITH_WALL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is held.
`define GMPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define GMPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/gmps_pkg.sv */
// Shared types and constants of the grid path-sum core.
// No dependencies; used by gmps_pe and the top level.
package gmps_pkg;

    // Configuration register width and index codes.
    localparam int REG_BITS      = 11;
    localparam int CFG_ADDR_BITS = 3;
    localparam int ROW_LIMIT     = 1024;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRID_ROWS  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRID_COLS  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WALL_A_ROW = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WALL_A_COL = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WALL_B_ROW = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WALL_B_COL = 3'd5;

    // Position and wall facts of one cell, worked out when the cell is taken.
    typedef struct packed {
        logic first;      // top-left cell
        logic row_zero;   // no cell above
        logic col_zero;   // no cell to the left
        logic blk_above;  // wall blocks the move from above
        logic blk_left;   // wall blocks the move from the left
        logic done;       // last cell of the grid
    } t_cell_flags;

endpackage

/* hdl/gmps_pe.sv */
// Cell update of the grid path-sum core: best of the neighbors plus own value.
// Depends on gmps_pkg for the cell flag struct.
module gmps_pe #(
    parameter int VALUE_BITS = 11,
    parameter int SUM_BITS   = 24
) (
    input  gmps_pkg::t_cell_flags        i_flags,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic signed [SUM_BITS-1:0]   i_up_sum,
    input  logic                         i_up_ok,
    input  logic signed [SUM_BITS-1:0]   i_left_sum,
    input  logic                         i_left_ok,
    output logic signed [SUM_BITS-1:0]   o_sum,
    output logic                         o_ok
);

    localparam int EW = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
    localparam logic signed [EW-1:0] SUM_HI = EW'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SUM_LO = -SUM_HI - EW'(1);

    logic                       up_use;
    logic                       left_use;
    logic signed [SUM_BITS-1:0] best;
    logic signed [EW-1:0]       total;

    always_comb begin
        up_use   = !i_flags.row_zero && !i_flags.blk_above && i_up_ok;
        left_use = !i_flags.col_zero && !i_flags.blk_left && i_left_ok;

        if (i_flags.first) begin
            best = '0;
        end else if (up_use && left_use) begin
            best = (i_up_sum > i_left_sum) ? i_up_sum : i_left_sum;
        end else if (up_use) begin
            best = i_up_sum;
        end else begin
            best = i_left_sum;
        end

        total = EW'(best) + EW'(i_value);
        o_ok  = i_flags.first || up_use || left_use;

        if (!o_ok) begin
            o_sum = '0;
        end else if (total > SUM_HI) begin
            o_sum = SUM_HI[SUM_BITS-1:0];
        end else if (total < SUM_LO) begin
            o_sum = SUM_LO[SUM_BITS-1:0];
        end else begin
            o_sum = total[SUM_BITS-1:0];
        end
    end

endmodule

/* hdl/grid_max_path_sum_with_wall_core.sv */
// Grid path-sum core: one cell beat in, one result beat out, one beat per cycle
// while the result stream keeps up. The accept edge loads the cell stage and the
// line-buffer read; the output register is loaded as the cell stage moves on, which
// waits while the result stream stalls. Reset clears the position, the pipeline
// and the configuration to its reset values; the line buffer is not cleared.
module grid_max_path_sum_with_wall_core #(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 11,
    parameter int SUM_BITS   = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [gmps_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [gmps_pkg::REG_BITS-1:0]          i_cfg_wdata,
    // Cell stream; tdata: cell_value.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // Result stream; tdata: best_sum, reachable. tlast: grid_done.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SUM_BITS+1+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int OUT_W = ((SUM_BITS + 1 + 7) / 8) * 8;
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(gmps_pkg::ROW_LIMIT);
    localparam int RB    = gmps_pkg::REG_BITS;
    localparam int CMPW  = ((CW > RB) ? CW : RB) + 1;

    // Configuration registers.
    logic [RB-1:0] r_grid_rows, r_grid_cols;
    logic [RB-1:0] r_wall_a_row, r_wall_a_col, r_wall_b_row, r_wall_b_col;

    // Position of the next cell.
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;

    // Cell stage.
    logic                          r_s1_v;
    logic signed [VALUE_BITS-1:0]  r_s1_value;
    logic [CW-1:0]                 r_s1_col;
    logic                          r_s1_fwd;
    gmps_pkg::t_cell_flags         r_s1_flags;
    logic [SUM_BITS:0]             r_up;

    // Line buffer: reachable bit over sum, one entry per column.
    logic [SUM_BITS:0] r_line [MAX_COLS];

    // Previous cell result.
    logic signed [SUM_BITS-1:0] r_left_sum;
    logic                       r_left_ok;

    // Output register.
    logic                       r_out_v;
    logic signed [SUM_BITS-1:0] r_out_sum;
    logic                       r_out_ok;
    logic                       r_out_done;

    logic                  accept;
    logic                  s1_go;
    logic [CMPW-1:0]       cols_cl;
    logic [CW-1:0]         cols_m1;
    logic [RB-1:0]         rows_cl;
    logic [RW-1:0]         rows_m1;
    logic [CW-1:0]         c_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  vertical;
    logic [CMPW-1:0]       r_ext, c_ext;
    logic [CMPW-1:0]       lo_r, hi_r, lo_c, hi_c;
    gmps_pkg::t_cell_flags n_flags;
    logic [SUM_BITS:0]     up_sel;
    logic signed [SUM_BITS-1:0] res_sum;
    logic                  res_ok;

    assign s1_go         = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_s1_v || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Position, size clamps and wall tests for the incoming cell.
    always_comb begin
        if (r_grid_cols == '0) begin
            cols_cl = CMPW'(1);
        end else if (CMPW'(r_grid_cols) > CMPW'(MAX_COLS)) begin
            cols_cl = CMPW'(MAX_COLS);
        end else begin
            cols_cl = CMPW'(r_grid_cols);
        end
        cols_m1 = CW'(cols_cl - CMPW'(1));

        if (r_grid_rows == '0) begin
            rows_cl = RB'(1);
        end else if (r_grid_rows > RB'(gmps_pkg::ROW_LIMIT)) begin
            rows_cl = RB'(gmps_pkg::ROW_LIMIT);
        end else begin
            rows_cl = r_grid_rows;
        end
        rows_m1 = RW'(rows_cl - RB'(1));

        c_eff    = (r_col > cols_m1) ? cols_m1 : r_col;
        last_col = (r_col >= cols_m1);
        last_row = (r_row >= rows_m1);

        r_ext    = CMPW'(r_row);
        c_ext    = CMPW'(c_eff);
        vertical = (r_wall_a_row != r_wall_b_row);
        lo_r = CMPW'((r_wall_a_row < r_wall_b_row) ? r_wall_a_row : r_wall_b_row);
        hi_r = CMPW'((r_wall_a_row < r_wall_b_row) ? r_wall_b_row : r_wall_a_row);
        lo_c = CMPW'((r_wall_a_col < r_wall_b_col) ? r_wall_a_col : r_wall_b_col);
        hi_c = CMPW'((r_wall_a_col < r_wall_b_col) ? r_wall_b_col : r_wall_a_col);

        n_flags.row_zero  = (r_row == '0);
        n_flags.col_zero  = (c_eff == '0);
        n_flags.first     = n_flags.row_zero && n_flags.col_zero;
        n_flags.blk_left  = vertical && (c_ext == CMPW'(r_wall_a_col))
                            && (r_ext >= lo_r) && (r_ext < hi_r);
        n_flags.blk_above = !vertical && (r_ext == CMPW'(r_wall_a_row))
                            && (c_ext >= lo_c) && (c_ext < hi_c);
        n_flags.done      = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= RB'(1);
            r_grid_cols  <= RB'(1);
            r_wall_a_row <= '0;
            r_wall_a_col <= '0;
            r_wall_b_row <= '0;
            r_wall_b_col <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gmps_pkg::CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_wdata;
                gmps_pkg::CFG_GRID_COLS:  r_grid_cols  <= i_cfg_wdata;
                gmps_pkg::CFG_WALL_A_ROW: r_wall_a_row <= i_cfg_wdata;
                gmps_pkg::CFG_WALL_A_COL: r_wall_a_col <= i_cfg_wdata;
                gmps_pkg::CFG_WALL_B_ROW: r_wall_b_row <= i_cfg_wdata;
                gmps_pkg::CFG_WALL_B_COL: r_wall_b_col <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= c_eff + CW'(1);
            end
        end
    end

    // The cell ahead writes its column on this same edge, so a read of that
    // column sees stale data; the forward flag picks the left register instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_value <= s_axis_tdata[VALUE_BITS-1:0];
            r_s1_col   <= c_eff;
            r_s1_flags <= n_flags;
            r_s1_fwd   <= s1_go && (r_s1_col == c_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up <= r_line[c_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_line[r_s1_col] <= {res_ok, res_sum};
        end
    end

    assign up_sel = r_s1_fwd ? {r_left_ok, r_left_sum} : r_up;

    gmps_pe #(
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_pe (
        .i_flags    (r_s1_flags),
        .i_value    (r_s1_value),
        .i_up_sum   (up_sel[SUM_BITS-1:0]),
        .i_up_ok    (up_sel[SUM_BITS]),
        .i_left_sum (r_left_sum),
        .i_left_ok  (r_left_ok),
        .o_sum      (res_sum),
        .o_ok       (res_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum <= '0;
            r_left_ok  <= 1'b0;
        end else if (s1_go) begin
            r_left_sum <= res_sum;
            r_left_ok  <= res_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_go) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_sum  <= res_sum;
            r_out_ok   <= res_ok;
            r_out_done <= r_s1_flags.done;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'({r_out_ok, r_out_sum});
    assign m_axis_tlast  = r_out_done;

`include "grid_max_path_sum_with_wall_core_assert.svh"

    `GMPS_ASSERT(a_first_reach, i_clk, i_rst_n, (s1_go && r_s1_flags.first) |=> r_out_ok, "top-left cell must be reachable")
    `GMPS_ASSERT(a_unreach_zero, i_clk, i_rst_n, (r_out_v && !r_out_ok) |-> (r_out_sum == '0), "unreachable cell must carry a zero sum")
    `GMPS_ASSERT(a_wrap_pos, i_clk, i_rst_n, (accept && n_flags.done) |=> (r_row == '0 && r_col == '0), "position must return to the origin after the last cell")
    `GMPS_ASSERT(a_s1_hold, i_clk, i_rst_n, (r_s1_v && !s1_go) |=> (r_s1_v && $stable(r_s1_col)), "stalled cell stage must keep its cell")

endmodule

/* test/grid_max_path_sum_with_wall_core_test.sv */
// Self-checking testbench for grid_max_path_sum_with_wall_core.
// Drives cell beats and wall/size writes, predicts every result beat and compares it.
// Depends on gmps_pkg and the core RTL only.
module grid_max_path_sum_with_wall_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS   = 1024;
    localparam int VALUE_BITS = 11;
    localparam int SUM_BITS   = 24;
    localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((SUM_BITS + 1 + 7) / 8) * 8;
    localparam longint SUM_MAX = (longint'(1) << (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [gmps_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [gmps_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [VALUE_BITS-1:0] CELL_MIN = 11'h400;
    localparam logic [VALUE_BITS-1:0] CELL_MAX = 11'h3FF;

    typedef struct {
        logic [SUM_BITS-1:0] best_sum;
        logic                reachable;
        logic                grid_done;
    } t_path_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [gmps_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr = '0;
    logic [gmps_pkg::REG_BITS-1:0]       i_cfg_wdata = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [IN_W-1:0]                     s_axis_tdata = '0;   // cell_value
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                    m_axis_tdata;        // best_sum, reachable
    logic                                m_axis_tlast;        // grid_done

    grid_max_path_sum_with_wall_core #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: configuration, line of the row above, previous cell, position.
    int unsigned  cfg_rows = 1;
    int unsigned  cfg_cols = 1;
    int unsigned  wall_r0 = 0;
    int unsigned  wall_c0 = 0;
    int unsigned  wall_r1 = 0;
    int unsigned  wall_c1 = 0;
    longint       upper_sum [MAX_COLS];
    bit           upper_ok [MAX_COLS];
    longint       prev_sum = 0;
    bit           prev_ok = 1'b0;
    int unsigned  at_row = 0;
    int unsigned  at_col = 0;

    t_path_result expected_paths [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    function automatic int unsigned used_rows();
        if (cfg_rows < 1) return 1;
        if (cfg_rows > gmps_pkg::ROW_LIMIT) return gmps_pkg::ROW_LIMIT;
        return cfg_rows;
    endfunction

    function automatic int unsigned used_cols();
        if (cfg_cols < 1) return 1;
        if (cfg_cols > MAX_COLS) return MAX_COLS;
        return cfg_cols;
    endfunction

    function automatic int unsigned cells_to_grid_end();
        int unsigned rows;
        int unsigned cols;
        int unsigned c;
        rows = used_rows();
        cols = used_cols();
        c = (at_col >= cols) ? cols - 1 : at_col;
        if (at_row >= rows - 1) return cols - c;
        return (rows - 1 - at_row) * cols + (cols - c);
    endfunction

    // Best path into the next cell; advances the predictor's position.
    function automatic t_path_result next_best_path(input logic [VALUE_BITS-1:0] raw);
        int unsigned  rows;
        int unsigned  cols;
        int unsigned  r;
        int unsigned  c;
        int unsigned  lo;
        int unsigned  hi;
        bit           last_col;
        bit           last_row;
        bit           blk_left;
        bit           blk_above;
        bit           up_ok;
        bit           lf_ok;
        bit           ok;
        longint       best;
        longint       total;
        t_path_result res;
        rows = used_rows();
        cols = used_cols();
        r = at_row;
        c = (at_col >= cols) ? cols - 1 : at_col;
        last_col = (c == cols - 1);
        last_row = (r >= rows - 1);
        blk_left = 1'b0;
        blk_above = 1'b0;
        if (wall_r0 != wall_r1) begin
            lo = (wall_r0 < wall_r1) ? wall_r0 : wall_r1;
            hi = (wall_r0 < wall_r1) ? wall_r1 : wall_r0;
            blk_left = (c == wall_c0) && (r >= lo) && (r < hi);
        end else begin
            lo = (wall_c0 < wall_c1) ? wall_c0 : wall_c1;
            hi = (wall_c0 < wall_c1) ? wall_c1 : wall_c0;
            blk_above = (r == wall_r0) && (c >= lo) && (c < hi);
        end
        if (r == 0 && c == 0) begin
            ok = 1'b1;
            best = 0;
        end else begin
            up_ok = (r != 0) && !blk_above && upper_ok[c];
            lf_ok = (c != 0) && !blk_left && prev_ok;
            ok = up_ok || lf_ok;
            if (up_ok && lf_ok)
                best = (upper_sum[c] > prev_sum) ? upper_sum[c] : prev_sum;
            else if (up_ok)
                best = upper_sum[c];
            else
                best = prev_sum;
        end
        total = 0;
        if (ok) begin
            total = best + longint'($signed(raw));
            if (total > SUM_MAX) total = SUM_MAX;
            if (total < SUM_MIN) total = SUM_MIN;
        end
        upper_sum[c] = total;
        upper_ok[c] = ok;
        prev_sum = total;
        prev_ok = ok;
        if (last_col) begin
            at_col = 0;
            at_row = last_row ? 0 : r + 1;
        end else begin
            at_col = c + 1;
        end
        res.best_sum = total[SUM_BITS-1:0];
        res.reachable = ok;
        res.grid_done = last_col && last_row;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [SUM_BITS-1:0] want,
                                 input logic [SUM_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endtask

    // Result side: random stalls and the check of every accepted beat.
    always @(posedge i_clk) begin
        t_path_result want;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_paths.size() == 0) begin
                note_mismatch("unexpected beat", '0, m_axis_tdata[SUM_BITS-1:0]);
            end else begin
                want = expected_paths.pop_front();
                if (m_axis_tdata[SUM_BITS-1:0] !== want.best_sum)
                    note_mismatch("best_sum", want.best_sum, m_axis_tdata[SUM_BITS-1:0]);
                if (m_axis_tdata[SUM_BITS] !== want.reachable)
                    note_mismatch("reachable", SUM_BITS'(want.reachable),
                                  SUM_BITS'(m_axis_tdata[SUM_BITS]));
                if (m_axis_tlast !== want.grid_done)
                    note_mismatch("grid_done", SUM_BITS'(want.grid_done),
                                  SUM_BITS'(m_axis_tlast));
            end
        end
    end

    task automatic send_cell(input logic [VALUE_BITS-1:0] value);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - VALUE_BITS){1'b0}}, value};
        expected_paths.push_back(next_best_path(value));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_cell();
        int unsigned pick;
        pick = $urandom();
        case ($urandom_range(0, 7))
            0: return CELL_MIN;
            1: return CELL_MAX;
            default: return pick[VALUE_BITS-1:0];
        endcase
    endfunction

    // Drains the pipeline so that the block is idle before registers change.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_paths.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The enable is lowered again after each write, so no two writes share a step.
    task automatic write_reg(input logic [gmps_pkg::CFG_ADDR_BITS-1:0] idx,
                             input int unsigned value);
        int unsigned v;
        v = value & 32'h7FF;
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v[gmps_pkg::REG_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            gmps_pkg::CFG_GRID_ROWS:  cfg_rows = v;
            gmps_pkg::CFG_GRID_COLS:  cfg_cols = v;
            gmps_pkg::CFG_WALL_A_ROW: wall_r0 = v;
            gmps_pkg::CFG_WALL_A_COL: wall_c0 = v;
            gmps_pkg::CFG_WALL_B_ROW: wall_r1 = v;
            gmps_pkg::CFG_WALL_B_COL: wall_c1 = v;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols);
        write_reg(gmps_pkg::CFG_GRID_ROWS, rows);
        write_reg(gmps_pkg::CFG_GRID_COLS, cols);
    endtask

    task automatic set_wall(input int unsigned r0, input int unsigned c0,
                            input int unsigned r1, input int unsigned c1);
        write_reg(gmps_pkg::CFG_WALL_A_ROW, r0);
        write_reg(gmps_pkg::CFG_WALL_A_COL, c0);
        write_reg(gmps_pkg::CFG_WALL_B_ROW, r1);
        write_reg(gmps_pkg::CFG_WALL_B_COL, c1);
    endtask

    // Out of reset the grid is 1x1, so every beat is its own finished grid.
    task automatic test_reset_state();
        send_cell(CELL_MIN);
        send_cell(CELL_MAX);
    endtask

    task automatic test_open_grid();
        wait_idle();
        set_grid(2, 3);
        set_wall(0, 0, 0, 0);
        send_cell(CELL_MAX);
        send_cell(CELL_MIN);
        send_cell(11'd5);
        send_cell(-11'sd7);
        send_cell(CELL_MAX);
        send_cell(CELL_MIN);
    endtask

    // A vertical wall down column 1 cuts the grid in two; spare indexes must not matter.
    task automatic test_vertical_wall();
        wait_idle();
        set_wall(0, 1, 2, 1);
        write_reg(CFG_SPARE_LO, 2047);
        write_reg(CFG_SPARE_HI, 0);
        repeat (6) send_cell(random_cell());
    endtask

    // Horizontal wall with its endpoints given right to left and running off the grid.
    task automatic test_horizontal_wall();
        wait_idle();
        set_wall(1, 3, 1, 0);
        repeat (6) send_cell(random_cell());
    endtask

    task automatic test_zero_size();
        wait_idle();
        set_grid(0, 0);
        send_cell(CELL_MAX);
        send_cell(CELL_MIN);
    endtask

    // Shrinking the grid mid-row clamps the column and ends the grid at once.
    task automatic test_resize_mid_grid();
        wait_idle();
        set_grid(3, 3);
        set_wall(0, 0, 0, 0);
        repeat (4) send_cell(random_cell());
        wait_idle();
        set_grid(1, 1);
        repeat (3) send_cell(random_cell());
    endtask

    task automatic test_large_grids();
        send_idle_pct = 36;
        recv_stall_pct = 36;
        wait_idle();
        set_grid(2047, 1);
        set_wall(0, 0, 0, 0);
        repeat (1024) send_cell(random_cell());
        wait_idle();
        set_grid(1, 2047);
        repeat (1024) send_cell(random_cell());
    endtask

    // New sizes and wall; mid-grid the width may only shrink so that every
    // line entry read has been written by the row above.
    task automatic shuffle_setup();
        int unsigned rows;
        int unsigned cols;
        int unsigned er;
        int unsigned ec;
        int unsigned lo;
        int unsigned hi;
        int unsigned c;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 15))
                0: rows = 0;
                1: rows = $urandom_range(1025, 2047);
                default: rows = $urandom_range(1, 6);
            endcase
            if (at_row == 0 && at_col == 0) begin
                case ($urandom_range(0, 15))
                    0: cols = 0;
                    1: cols = $urandom_range(9, 40);
                    default: cols = $urandom_range(1, 8);
                endcase
            end else begin
                cols = $urandom_range(0, used_cols());
            end
            set_grid(rows, cols);
        end
        er = used_rows();
        ec = used_cols();
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
                0: set_wall($urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
                1: begin
                    lo = $urandom_range(0, er);
                    c = $urandom_range(0, ec);
                    set_wall(lo, c, lo, c);
                end
                2, 3, 4: begin
                    lo = $urandom_range(0, er);
                    hi = $urandom_range(0, er + 1);
                    if (hi == lo) hi = lo + 1;
                    c = $urandom_range(0, ec);
                    if ($urandom_range(0, 1) == 0)
                        set_wall(lo, c, hi, $urandom_range(0, ec + 1));
                    else
                        set_wall(hi, c, lo, $urandom_range(0, ec + 1));
                end
                default: begin
                    lo = $urandom_range(0, er);
                    set_wall(lo, $urandom_range(0, ec + 1), lo, $urandom_range(0, ec + 1));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      $urandom_range(0, 2047));
    endtask

    // Mostly whole grids; a third of the bursts stop part way through one.
    task automatic test_random_grids(input int send_pct, input int stall_pct,
                                     input int cell_count);
        int          sent;
        int unsigned left;
        int unsigned burst;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < cell_count) begin
            wait_idle();
            shuffle_setup();
            left = cells_to_grid_end();
            burst = left;
            if (left > 1 && $urandom_range(0, 2) == 0) burst = $urandom_range(1, left - 1);
            if (burst > 200) burst = $urandom_range(1, 200);
            repeat (burst) send_cell(random_cell());
            sent += burst;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_open_grid();
        test_vertical_wall();
        test_horizontal_wall();
        test_zero_size();
        test_resize_mid_grid();
        test_large_grids();
        test_random_grids(0, 0, 50);
        test_random_grids(46, 0, 50);
        test_random_grids(0, 46, 50);
        test_random_grids(36, 36, 50);
        wait_idle();
        if (mismatch_count == 0 && expected_paths.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/gmps_pkg.sv
hdl/gmps_pe.sv
hdl/grid_max_path_sum_with_wall_core.sv
test/grid_max_path_sum_with_wall_core_test.sv
